// ===== src/tcw_pkg.sv =====
package tcw_pkg;

   // Default geometry of the console.
   localparam int DEF_COLUMNS      = 80;
   localparam int DEF_ROWS         = 25;
   localparam int DEF_MEMORY_CELLS = 8192;

   // Fixed field widths of the channels.
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = 16;
   localparam int ADDR_W  = 13;
   localparam int INDEX_W = 2;

   // Command slots in the order they are delivered.
   localparam int NUM_SLOTS = 5;

   // Reset values of the configuration registers.
   localparam logic [ATTR_W-1:0] RESET_TEXT_ATTR  = 8'h07;
   localparam logic [CELL_W-1:0] RESET_ERASE_CELL = 16'h0720;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] CSR_TEXT_ATTR  = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_ERASE_CELL = 2'd1;

   // Control bytes.
   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

   typedef enum logic [2:0] {
      OP_WRITE      = 3'd0,
      OP_FILL_ROW   = 3'd1,
      OP_COPY       = 3'd2,
      OP_SET_START  = 3'd3,
      OP_SET_CURSOR = 3'd4,
      OP_FILL_ALL   = 3'd5
   } op_type;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] char_byte;
      logic              last_in;
   } item_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      cmd_type [NUM_SLOTS-1:0] cmd;
      logic    [NUM_SLOTS-1:0] en;
   } bundle_type;

endpackage

// ===== src/tcw_in_stage.sv =====
module tcw_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcw_pkg::item_type req_item,
   input  logic              slot_free,
   output logic              take,
   output tcw_pkg::item_type item
);
   import tcw_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // The held item moves on as soon as the command buffer can take its commands.
   assign take      = valid_ff && slot_free;
   assign req_ready = !valid_ff || slot_free;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== src/tcw_engine.sv =====
module tcw_engine #(
   parameter int COLUMNS      = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS         = tcw_pkg::DEF_ROWS,
   parameter int MEMORY_CELLS = tcw_pkg::DEF_MEMORY_CELLS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  tcw_pkg::item_type           item,
   input  logic [tcw_pkg::ATTR_W-1:0]  text_attr,
   input  logic [tcw_pkg::CELL_W-1:0]  erase_cell,
   output tcw_pkg::bundle_type         bundle
);
   import tcw_pkg::*;

   localparam int AW     = $clog2(MEMORY_CELLS);
   localparam int COL_W  = $clog2(COLUMNS + 1);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int SUM_W  = AW + 2;
   localparam int SCREEN = COLUMNS * ROWS;

   localparam logic [AW:0]      MEM_P      = (AW+1)'(MEMORY_CELLS);
   localparam logic [AW:0]      COL_P      = (AW+1)'(COLUMNS);
   localparam logic [AW-1:0]    COL_A      = AW'(COLUMNS);
   localparam logic [AW-1:0]    CELL_TOP   = AW'(MEMORY_CELLS - 1);
   localparam logic [AW-1:0]    SCREEN_A   = AW'(SCREEN % MEMORY_CELLS);
   localparam logic [SUM_W-1:0] SCROLL_LIM = SUM_W'(SCREEN + COLUMNS);
   localparam logic [SUM_W-1:0] MEM_S      = SUM_W'(MEMORY_CELLS);
   localparam logic [COL_W-1:0] COL_MAX    = COL_W'(COLUMNS);
   localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);

   logic [AW-1:0]    start_ff, start_in;
   logic [AW-1:0]    cursor_ff, cursor_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             printable;
   logic             wrap;
   logic             do_down;
   logic             at_bottom;
   logic             rebase;
   logic [AW-1:0]    start_scr;
   logic [AW-1:0]    fill_addr;
   logic [AW:0]      diff;
   logic [AW-1:0]    rebased;
   logic [AW-1:0]    cursor_dn;
   logic [ROW_W-1:0] row_dn;
   logic [AW-1:0]    start_dn;
   logic [ROW_W-1:0] ls_row;
   logic [AW-1:0]    ls_start;
   logic [AW:0]      row_off;
   logic [AW:0]      row_off_m;
   logic [AW-1:0]    ls_cursor;
   logic [AW-1:0]    cursor_dec;
   logic [AW-1:0]    print_pos;

   // Sum of two cells modulo the memory size; both operands are below it.
   function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= MEM_P) begin
         s = s - MEM_P;
      end
      return s[AW-1:0];
   endfunction

   always_comb begin
      case (item.char_byte)
         CH_NUL, CH_BEL, CH_HT, CH_VT, CH_BS, CH_LF, CH_FF, CH_CR, CH_DEL: begin
            printable = 1'b0;
         end
         default: begin
            printable = 1'b1;
         end
      endcase
   end

   assign wrap      = printable && (column_ff >= COL_MAX);
   assign do_down   = (item.char_byte == CH_LF) || (item.char_byte == CH_FF) || wrap;
   assign at_bottom = (row_ff == ROW_LAST);

   // A scroll below the end of memory first moves the screen back to cell zero.
   assign rebase    = (SUM_W'(start_ff) + SCROLL_LIM) >= MEM_S;
   assign start_scr = rebase ? COL_A : start_ff + COL_A;
   assign fill_addr = rebase ? SCREEN_A : AW'(SUM_W'(start_ff) + SUM_W'(SCREEN));

   always_comb begin
      diff = {1'b0, cursor_ff} - {1'b0, start_ff};
      if (cursor_ff < start_ff) begin
         diff = diff + MEM_P;
      end
   end
   assign rebased = diff[AW-1:0];

   assign cursor_dn = add_mod((at_bottom && rebase) ? rebased : cursor_ff, COL_A);
   assign row_dn    = at_bottom ? row_ff : row_ff + ROW_W'(1);
   assign start_dn  = at_bottom ? start_scr : start_ff;

   // Start of the cursor's line, after any move down.
   assign ls_row    = do_down ? row_dn : row_ff;
   assign ls_start  = do_down ? start_dn : start_ff;
   assign row_off   = (AW+1)'(ls_row) * COL_P;
   assign row_off_m = (row_off >= MEM_P) ? row_off - MEM_P : row_off;
   assign ls_cursor = add_mod(ls_start, row_off_m[AW-1:0]);

   assign cursor_dec = (cursor_ff == '0) ? CELL_TOP : cursor_ff - AW'(1);
   assign print_pos  = wrap ? ls_cursor : cursor_ff;

   always_comb begin
      start_in  = start_ff;
      cursor_in = cursor_ff;
      column_in = column_ff;
      row_in    = row_ff;
      bundle    = '0;

      if (item.kind) begin
         start_in  = '0;
         cursor_in = '0;
         column_in = '0;
         row_in    = '0;
         bundle.cmd[0] = '{op: OP_SET_CURSOR, addr: '0, data: '0};
         bundle.cmd[1] = '{op: OP_SET_START, addr: '0, data: '0};
         bundle.cmd[2] = '{op: OP_FILL_ALL, addr: '0, data: erase_cell};
         bundle.en     = NUM_SLOTS'(3'b111);
      end else begin
         if (do_down && at_bottom) begin
            bundle.cmd[0] = '{op: OP_COPY, addr: '0, data: CELL_W'(start_ff)};
            bundle.cmd[1] = '{op: OP_FILL_ROW, addr: ADDR_W'(fill_addr), data: erase_cell};
            bundle.cmd[2] = '{op: OP_SET_START, addr: ADDR_W'(start_scr), data: '0};
            bundle.en[0]  = rebase;
            bundle.en[1]  = 1'b1;
            bundle.en[2]  = 1'b1;
         end

         case (item.char_byte)
            CH_NUL, CH_BEL, CH_HT, CH_VT: begin
            end
            CH_BS: begin
               if (column_ff != '0) begin
                  column_in     = column_ff - COL_W'(1);
                  cursor_in     = cursor_dec;
                  bundle.cmd[3] = '{op: OP_WRITE, addr: ADDR_W'(cursor_dec), data: erase_cell};
                  bundle.en[3]  = 1'b1;
               end
            end
            CH_LF: begin
               start_in  = start_dn;
               row_in    = row_dn;
               cursor_in = ls_cursor;
               column_in = '0;
            end
            CH_FF: begin
               start_in  = start_dn;
               row_in    = row_dn;
               cursor_in = cursor_dn;
            end
            CH_CR: begin
               cursor_in = ls_cursor;
               column_in = '0;
            end
            CH_DEL: begin
               bundle.cmd[3] = '{op: OP_WRITE, addr: ADDR_W'(cursor_ff), data: erase_cell};
               bundle.en[3]  = 1'b1;
            end
            default: begin
               if (wrap) begin
                  start_in  = start_dn;
                  row_in    = row_dn;
                  column_in = COL_W'(1);
               end else begin
                  column_in = column_ff + COL_W'(1);
               end
               cursor_in     = add_mod(print_pos, AW'(1));
               bundle.cmd[3] = '{op: OP_WRITE, addr: ADDR_W'(print_pos),
                                 data: {text_attr, item.char_byte}};
               bundle.en[3]  = 1'b1;
            end
         endcase

         if (item.last_in) begin
            bundle.cmd[4] = '{op: OP_SET_CURSOR, addr: ADDR_W'(cursor_in), data: '0};
            bundle.en[4]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         cursor_ff <= '0;
         column_ff <= '0;
         row_ff    <= '0;
      end else if (take) begin
         start_ff  <= start_in;
         cursor_ff <= cursor_in;
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== src/tcw_cmd_queue.sv =====
module tcw_cmd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  tcw_pkg::bundle_type        bundle,
   output logic                       slot_free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tcw_pkg::op_type            rsp_op,
   output logic [tcw_pkg::ADDR_W-1:0] rsp_cell_addr,
   output logic [tcw_pkg::CELL_W-1:0] rsp_cell_data,
   output logic                       rsp_last_of_run
);
   import tcw_pkg::*;

   cmd_type [NUM_SLOTS-1:0] cmd_ff;
   logic    [NUM_SLOTS-1:0] en_ff, en_in;
   logic    [NUM_SLOTS-1:0] sel;
   logic    [NUM_SLOTS-1:0] rest;
   cmd_type                 cur;
   logic                    fire;

   // The earliest enabled slot is the command on offer.
   assign sel  = en_ff & (~en_ff + NUM_SLOTS'(1));
   assign rest = en_ff & ~sel;

   always_comb begin
      cur = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (sel[i]) begin
            cur = cmd_ff[i];
         end
      end
   end

   assign rsp_valid       = (en_ff != '0);
   assign rsp_op          = cur.op;
   assign rsp_cell_addr   = cur.addr;
   assign rsp_cell_data   = cur.data;
   assign rsp_last_of_run = (rest == '0);

   assign fire      = rsp_valid && rsp_ready;
   assign slot_free = !rsp_valid || (fire && (rest == '0));

   always_comb begin
      en_in = en_ff;
      if (load) begin
         en_in = bundle.en;
      end else if (fire) begin
         en_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0;
      end else begin
         en_ff <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= bundle.cmd;
      end
   end

endmodule

// ===== src/text_console_writer_core.sv =====
// Console byte writer: an input transaction is taken every cycle while each leaves at most
// one command and the receiver takes each command; its first command is offered after the
// input register and then the command buffer register, which waits until the buffer is free.
// A transaction with n commands (five at most) holds the buffer and the input until the last is taken.
// Synchronous active-high reset clears the cursor, start cell, column, row and the queues,
// and sets text_attr to 0x07 and erase_cell to 0x0720.
module text_console_writer_core #(
   parameter int COLUMNS      = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS         = tcw_pkg::DEF_ROWS,
   parameter int MEMORY_CELLS = tcw_pkg::DEF_MEMORY_CELLS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_byte,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tcw_pkg::op_type             rsp_op,
   output logic [tcw_pkg::ADDR_W-1:0]  rsp_cell_addr,
   output logic [tcw_pkg::CELL_W-1:0]  rsp_cell_data,
   output logic                        rsp_last_of_run,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tcw_pkg::INDEX_W-1:0] csr_index,
   input  logic [tcw_pkg::CELL_W-1:0]  csr_wdata
);
   import tcw_pkg::*;

   logic [ATTR_W-1:0] text_attr_ff;
   logic [CELL_W-1:0] erase_cell_ff;
   item_type          req_item;
   item_type          item;
   logic              take;
   logic              slot_free;
   bundle_type        bundle;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff  <= RESET_TEXT_ATTR;
         erase_cell_ff <= RESET_ERASE_CELL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEXT_ATTR: begin
               text_attr_ff <= csr_wdata[ATTR_W-1:0];
            end
            CSR_ERASE_CELL: begin
               erase_cell_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign req_item = '{kind: req_kind, char_byte: req_char_byte, last_in: req_last_in};

   tcw_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .slot_free (slot_free),
      .take      (take),
      .item      (item)
   );

   tcw_engine #(
      .COLUMNS      (COLUMNS),
      .ROWS         (ROWS),
      .MEMORY_CELLS (MEMORY_CELLS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .item       (item),
      .text_attr  (text_attr_ff),
      .erase_cell (erase_cell_ff),
      .bundle     (bundle)
   );

   tcw_cmd_queue u_cmd_queue (
      .clock           (clock),
      .reset           (reset),
      .load            (take),
      .bundle          (bundle),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_op          (rsp_op),
      .rsp_cell_addr   (rsp_cell_addr),
      .rsp_cell_data   (rsp_cell_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== verif/text_console_writer_core_tb.sv =====
`timescale 1ns / 1ps

module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam int COLS = DEF_COLUMNS;
   localparam int ROWS = DEF_ROWS;
   localparam int CELLS = DEF_MEMORY_CELLS;
   localparam int SCREEN = COLS * ROWS;
   // A scroll starting at or above this start cell copies the screen back to cell zero.
   localparam int REBASE_AT = CELLS - SCREEN - COLS;
   localparam int IDLE_PCT = 35;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT = 200000;
   // No register lives at this index, so a write to it must change nothing.
   localparam logic [INDEX_W-1:0] CSR_SPARE = 2'd2;

   typedef struct {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] data;
      logic              last;
   } console_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_kind = 1'b0;
   logic [CHAR_W-1:0] req_char_byte = '0;
   logic              req_last_in = 1'b0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   op_type            rsp_op;
   logic [ADDR_W-1:0] rsp_cell_addr;
   logic [CELL_W-1:0] rsp_cell_data;
   logic              rsp_last_of_run;

   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [CELL_W-1:0]  csr_wdata = '0;

   // Shadow of the console state, updated as each transaction is accepted.
   logic [ADDR_W-1:0] scr_start = '0;
   logic [ADDR_W-1:0] scr_cursor = '0;
   logic [6:0]        scr_col = '0;
   logic [4:0]        scr_row = '0;
   logic [ATTR_W-1:0] scr_attr = RESET_TEXT_ATTR;
   logic [CELL_W-1:0] scr_erase = RESET_ERASE_CELL;

   item_type        pending_items[$];
   console_cmd_type run_cmds[$];
   console_cmd_type expected_cmds[$];

   int req_issued;
   int req_accepted;
   int cycle_count;
   int errors;
   int commands_checked;
   int op_count[0:7];
   int hold_asked;
   int hold_served;
   int hold_left;
   bit calm;

   text_console_writer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_char_byte  (req_char_byte),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_op         (rsp_op),
      .rsp_cell_addr  (rsp_cell_addr),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ADDR_W-1:0] cell_at(int v);
      return ADDR_W'(v % CELLS);
   endfunction

   function automatic void add_cmd(op_type op, logic [ADDR_W-1:0] addr,
                                   logic [CELL_W-1:0] data);
      console_cmd_type c;
      c.op = op;
      c.addr = addr;
      c.data = data;
      c.last = 1'b0;
      run_cmds.push_back(c);
   endfunction

   function automatic void home_column();
      scr_cursor = cell_at(int'(scr_start) + int'(scr_row) * COLS);
      scr_col = '0;
   endfunction

   function automatic void advance_line();
      if (int'(scr_row) + 1 < ROWS) begin
         scr_row = scr_row + 1'b1;
         scr_cursor = cell_at(int'(scr_cursor) + COLS);
      end else begin
         if (int'(scr_start) >= REBASE_AT) begin
            add_cmd(OP_COPY, '0, CELL_W'(scr_start));
            scr_cursor = cell_at(int'(scr_cursor) + CELLS - int'(scr_start));
            scr_start = '0;
         end
         add_cmd(OP_FILL_ROW, cell_at(int'(scr_start) + SCREEN), scr_erase);
         scr_start = cell_at(int'(scr_start) + COLS);
         scr_cursor = cell_at(int'(scr_cursor) + COLS);
         add_cmd(OP_SET_START, scr_start, '0);
      end
   endfunction

   function automatic void predict_commands(item_type it);
      run_cmds.delete();
      if (it.kind) begin
         scr_start = '0;
         scr_cursor = '0;
         scr_col = '0;
         scr_row = '0;
         add_cmd(OP_SET_CURSOR, '0, '0);
         add_cmd(OP_SET_START, '0, '0);
         add_cmd(OP_FILL_ALL, '0, scr_erase);
      end else begin
         case (it.char_byte)
            CH_NUL, CH_BEL, CH_HT, CH_VT: ;
            CH_BS: begin
               if (scr_col > 0) begin
                  scr_col = scr_col - 1'b1;
                  scr_cursor = cell_at(int'(scr_cursor) + CELLS - 1);
                  add_cmd(OP_WRITE, scr_cursor, scr_erase);
               end
            end
            CH_LF: begin
               advance_line();
               home_column();
            end
            CH_FF: advance_line();
            CH_CR: home_column();
            CH_DEL: add_cmd(OP_WRITE, scr_cursor, scr_erase);
            default: begin
               if (scr_col >= COLS) begin
                  advance_line();
                  home_column();
               end
               add_cmd(OP_WRITE, scr_cursor, {scr_attr, it.char_byte});
               scr_cursor = cell_at(int'(scr_cursor) + 1);
               scr_col = scr_col + 1'b1;
            end
         endcase
         // A cursor update follows even when the byte itself did nothing.
         if (it.last_in)
            add_cmd(OP_SET_CURSOR, scr_cursor, '0);
      end
      if (run_cmds.size() > 0)
         run_cmds[run_cmds.size() - 1].last = 1'b1;
      foreach (run_cmds[i])
         expected_cmds.push_back(run_cmds[i]);
   endfunction

   function automatic void flag_error(string msg);
      errors++;
      if (errors <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic bit coin(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic void add_item(logic kind, logic [CHAR_W-1:0] ch, logic last);
      item_type it;
      it.kind = kind;
      it.char_byte = ch;
      it.last_in = last;
      pending_items.push_back(it);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_printable();
      logic [CHAR_W-1:0] ch;
      bit ok;
      do begin
         ch = CHAR_W'($urandom_range(255));
         ok = 1'b1;
         case (ch)
            CH_NUL, CH_BEL, CH_BS, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR, CH_DEL: ok = 1'b0;
            default: ;
         endcase
      end while (!ok);
      return ch;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_ignored();
      case ($urandom_range(3))
         0: return CH_NUL;
         1: return CH_BEL;
         2: return CH_HT;
         default: return CH_VT;
      endcase
   endfunction

   // Random console traffic: lines of printable text broken up by control bytes and clears.
   function automatic void queue_mixed(int count);
      int target;
      int pick;
      int run;
      target = pending_items.size() + count;
      while (pending_items.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 4)
            add_item(1'b1, CHAR_W'($urandom_range(255)), coin(50));
         else if (pick < 20)
            add_item(1'b0, CH_LF, coin(30));
         else if (pick < 26)
            add_item(1'b0, CH_FF, coin(30));
         else if (pick < 31)
            add_item(1'b0, CH_CR, coin(30));
         else if (pick < 38)
            add_item(1'b0, CH_BS, coin(30));
         else if (pick < 43)
            add_item(1'b0, CH_DEL, coin(30));
         else if (pick < 50)
            add_item(1'b0, pick_ignored(), coin(40));
         else begin
            run = $urandom_range(90, 1);
            while (run > 0 && pending_items.size() < target) begin
               add_item(1'b0, pick_printable(), run == 1 ? coin(70) : coin(10));
               run--;
            end
         end
      end
   endfunction

   task automatic settle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_accepted != req_issued ||
             expected_cmds.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CELL_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      case (idx)
         CSR_TEXT_ATTR: scr_attr = value[ATTR_W-1:0];
         CSR_ERASE_CELL: scr_erase = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin : drive_req
      item_type item_out;
      if (!reset && (!req_valid || req_accepted == req_issued)) begin
         if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            item_out = pending_items.pop_front();
            req_kind <= item_out.kind;
            req_char_byte <= item_out.char_byte;
            req_last_in <= item_out.last_in;
            req_valid <= 1'b1;
            req_issued <= req_issued + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : watch
      console_cmd_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready) begin
         predict_commands(item_type'({req_kind, req_char_byte, req_last_in}));
         req_accepted <= req_accepted + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cmds.size() == 0) begin
            flag_error($sformatf({"command with nothing expected: ",
                                  "op %0d addr %0d data 0x%04h last %0b"},
                                 rsp_op, rsp_cell_addr, rsp_cell_data, rsp_last_of_run));
         end else begin
            want = expected_cmds.pop_front();
            commands_checked++;
            op_count[want.op]++;
            if (want.op !== rsp_op || want.addr !== rsp_cell_addr ||
                want.data !== rsp_cell_data || want.last !== rsp_last_of_run)
               flag_error($sformatf({"expected op %0d addr %0d data 0x%04h last %0b, ",
                                     "got op %0d addr %0d data 0x%04h last %0b"},
                                    want.op, want.addr, want.data, want.last, rsp_op,
                                    rsp_cell_addr, rsp_cell_data, rsp_last_of_run));
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("text_console_writer_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int downs;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every control byte, cursor updates on ignored bytes,
      // backspace at column zero and a clear that carries last_in.
      add_item(1'b1, CH_NUL, 1'b0);
      add_item(1'b0, 8'h41, 1'b0);
      add_item(1'b0, 8'hFF, 1'b1);
      add_item(1'b0, 8'h80, 1'b0);
      add_item(1'b0, 8'h01, 1'b0);
      add_item(1'b0, 8'h0E, 1'b0);
      add_item(1'b0, CH_BS, 1'b1);
      add_item(1'b0, CH_DEL, 1'b0);
      add_item(1'b0, CH_NUL, 1'b1);
      add_item(1'b0, CH_BEL, 1'b0);
      add_item(1'b0, CH_HT, 1'b0);
      add_item(1'b0, CH_VT, 1'b1);
      add_item(1'b0, CH_CR, 1'b1);
      add_item(1'b0, CH_BS, 1'b0);
      add_item(1'b0, CH_LF, 1'b1);
      add_item(1'b0, 8'h20, 1'b0);
      add_item(1'b0, CH_FF, 1'b0);
      add_item(1'b0, CH_FF, 1'b1);
      add_item(1'b0, 8'h7E, 1'b1);
      add_item(1'b1, 8'hFF, 1'b1);
      add_item(1'b0, 8'h06, 1'b1);
      settle();

      // Upper bits of the attribute write are ignored by the block.
      write_reg(CSR_TEXT_ATTR, 16'hFFFF);
      write_reg(CSR_ERASE_CELL, 16'hFFFF);
      queue_mixed(20);
      // The receiver holds off once during the phase, so the block backs up.
      hold_asked++;
      settle();

      write_reg(CSR_TEXT_ATTR, 16'h0000);
      write_reg(CSR_ERASE_CELL, 16'h0000);
      write_reg(CSR_SPARE, 16'hFFFF);

      // Walk the screen down until the start cell is past the rebase point with the
      // cursor on the bottom row, then fill a full line so the wrapping character
      // triggers copy, fill, new start, write and cursor update in one transaction.
      calm = 1'b1;
      downs = ROWS - 1 - int'(scr_row);
      if (int'(scr_start) < REBASE_AT)
         downs += (REBASE_AT - int'(scr_start) + COLS - 1) / COLS;
      for (int i = 0; i < downs; i++) begin
         add_item(1'b0, CH_LF, coin(20));
         if (coin(6)) begin
            case ($urandom_range(2))
               0: add_item(1'b0, pick_ignored(), coin(50));
               1: add_item(1'b0, CH_DEL, coin(50));
               default: repeat ($urandom_range(5, 1)) add_item(1'b0, pick_printable(), coin(20));
            endcase
         end
      end
      add_item(1'b0, CH_CR, 1'b0);
      repeat (COLS) add_item(1'b0, pick_printable(), coin(10));
      add_item(1'b0, pick_printable(), 1'b1);
      settle();
      calm = 1'b0;

      write_reg(CSR_TEXT_ATTR, CELL_W'($urandom_range(254, 1)));
      write_reg(CSR_ERASE_CELL, CELL_W'($urandom_range(65534, 1)));
      queue_mixed(10);
      settle();

      $display("Run covered %0d console transactions and checked %0d commands.",
               req_accepted, commands_checked);
      $display({"Commands seen: %0d cell writes, %0d scrolls, %0d rebases, ",
                "%0d clears, %0d cursor moves."},
               op_count[OP_WRITE], op_count[OP_FILL_ROW], op_count[OP_COPY],
               op_count[OP_FILL_ALL], op_count[OP_SET_CURSOR]);
      if (errors == 0)
         $display("text_console_writer_core_tb: done, clean");
      else
         $display("text_console_writer_core_tb: done, errors");
      $finish;
   end

endmodule
